FILE: rtl/call_stack_frame_unit_core_assert.svh
// Assertion macros shared by the call stack frame unit RTL.
// Depends on nothing; included by the controller and the datapath.
`ifndef CALL_STACK_FRAME_UNIT_CORE_ASSERT_SVH
`define CALL_STACK_FRAME_UNIT_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CSFU_ASSERT_IMPLY(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CSFU_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/csfu_pkg.sv
// Shared types and constants of the call stack frame unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package csfu_pkg;

  localparam int PTR_W           = 13;
  localparam int WORD_W          = 32;
  localparam int REQ_W           = 3;
  localparam int CNT_W           = 12;
  localparam int STATUS_W        = 3;
  localparam int DEF_STACK_DEPTH = 4096;
  localparam logic [PTR_W-1:0] LIMIT_RESET = 13'd4096;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_REF   = 3'd0,
    REQ_PUSH_NUM   = 3'd1,
    REQ_POP        = 3'd2,
    REQ_ADD_FRAME  = 3'd3,
    REQ_REL_FRAME  = 3'd4,
    REQ_PUSH_LOCAL = 3'd5,
    REQ_POP_LOCAL  = 3'd6
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_EMPTY  = 3'd2,
    ST_TAG    = 3'd3,
    ST_BOUNDS = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_ISSUE = 2'd1,
    S_READ  = 2'd2,
    S_CLEAR = 2'd3
  } state_e;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [WORD_W-1:0] value;
    logic [CNT_W-1:0]  local_count;
    logic [CNT_W-1:0]  local_index;
  } csfu_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   read_word;
    logic                read_is_ref;
    logic [PTR_W-1:0]    stack_top;
    logic [PTR_W-1:0]    frame_base;
  } csfu_out_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic ph_issue;
    logic ph_read;
    logic ph_clear;
    logic fire;
    logic publish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic go_read;
    logic go_clear;
    logic clear_last;
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/csfu_datapath.sv
// Datapath: request register, pointers, limit, slot memory and result register.
// Depends on csfu_pkg and call_stack_frame_unit_core_assert.svh.
`default_nettype none
`include "call_stack_frame_unit_core_assert.svh"

module csfu_datapath #(
  parameter int STACK_DEPTH = csfu_pkg::DEF_STACK_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [csfu_pkg::PTR_W-1:0] cfg_wdata,
  input  csfu_pkg::csfu_in_t         req,
  input  csfu_pkg::cmd_t             cmd,
  output csfu_pkg::sts_t             sts,
  output csfu_pkg::csfu_out_t        rsp
);
  import csfu_pkg::*;

  localparam int AW    = $clog2(STACK_DEPTH);
  localparam int SUM_W = PTR_W + 1;

  logic [WORD_W:0]       mem [STACK_DEPTH];
  logic [WORD_W:0]       rdata;
  csfu_in_t              r;
  logic [PTR_W-1:0]      top, top_next, fp, fp_next, stack_limit, lim;
  logic [CNT_W-1:0]      clr_cnt, clr_cnt_next;
  logic                  mem_we, mem_re;
  logic [SUM_W-1:0]      wr_ptr, rd_ptr, local_ptr;
  logic [WORD_W:0]       wdata;
  logic [STATUS_W-1:0]   status;
  logic [WORD_W-1:0]     rword;
  logic                  rref;
  logic                  top_full, frame_over, local_oob;
  logic [PTR_W-1:0]      fp_m1;

  assign lim = (int'(stack_limit) > STACK_DEPTH) ? PTR_W'(STACK_DEPTH) : stack_limit;
  assign top_full   = top >= lim;
  assign frame_over = ({1'b0, top} + SUM_W'(r.local_count) + SUM_W'(1)) > {1'b0, lim};
  assign local_ptr  = {1'b0, fp} + SUM_W'(r.local_index);
  assign local_oob  = local_ptr >= {1'b0, top};
  assign fp_m1      = fp - PTR_W'(1);

  always_comb begin
    top_next     = top;
    fp_next      = fp;
    clr_cnt_next = clr_cnt;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    wr_ptr       = {1'b0, top};
    rd_ptr       = {1'b0, top} - SUM_W'(1);
    wdata        = '0;
    status       = ST_OK;
    rword        = '0;
    rref         = 1'b0;
    sts          = '0;
    if (cmd.ph_issue) begin
      case (r.req_type)
        REQ_PUSH_REF, REQ_PUSH_NUM: begin
          if (top_full) begin
            status = ST_FULL;
          end else begin
            mem_we   = 1'b1;
            wdata    = {(r.req_type == REQ_PUSH_REF), r.value};
            top_next = top + PTR_W'(1);
          end
        end
        REQ_POP: begin
          if (top == '0) begin
            status = ST_EMPTY;
          end else begin
            mem_re      = 1'b1;
            sts.go_read = 1'b1;
          end
        end
        REQ_ADD_FRAME: begin
          if (top_full || frame_over) begin
            status = ST_FULL;
          end else begin
            // Save the old frame pointer as a number, then open the frame
            mem_we       = 1'b1;
            wdata        = {1'b0, WORD_W'(fp)};
            top_next     = top + PTR_W'(1);
            fp_next      = top + PTR_W'(1);
            clr_cnt_next = r.local_count;
            sts.go_clear = (r.local_count != '0);
          end
        end
        REQ_REL_FRAME: begin
          if (fp == '0) begin
            status = ST_EMPTY;
          end else begin
            mem_re      = 1'b1;
            rd_ptr      = {1'b0, fp_m1};
            sts.go_read = 1'b1;
          end
        end
        REQ_PUSH_LOCAL: begin
          if (local_oob) begin
            status = ST_BOUNDS;
          end else if (top_full) begin
            status = ST_FULL;
          end else begin
            mem_re      = 1'b1;
            rd_ptr      = local_ptr;
            sts.go_read = 1'b1;
          end
        end
        REQ_POP_LOCAL: begin
          if (local_oob) begin
            status = ST_BOUNDS;
          end else begin
            mem_re      = 1'b1;
            sts.go_read = 1'b1;
          end
        end
        default: begin
          status = ST_OK;
        end
      endcase
    end else if (cmd.ph_read) begin
      case (r.req_type)
        REQ_POP: begin
          top_next = top - PTR_W'(1);
          rword    = rdata[WORD_W-1:0];
          rref     = rdata[WORD_W];
        end
        REQ_REL_FRAME: begin
          if (rdata[WORD_W]) begin
            status = ST_TAG;
          end else if (rdata[WORD_W-1:0] > WORD_W'(fp_m1)) begin
            status = ST_BOUNDS;
          end else begin
            top_next = fp_m1;
            fp_next  = rdata[PTR_W-1:0];
          end
        end
        REQ_PUSH_LOCAL: begin
          mem_we   = 1'b1;
          wdata    = rdata;
          top_next = top + PTR_W'(1);
        end
        REQ_POP_LOCAL: begin
          mem_we   = 1'b1;
          wr_ptr   = local_ptr;
          wdata    = rdata;
          top_next = top - PTR_W'(1);
        end
        default: begin
          status = ST_OK;
        end
      endcase
    end else if (cmd.ph_clear) begin
      // Clear one local to a null reference
      mem_we         = 1'b1;
      wdata          = {1'b1, {WORD_W{1'b0}}};
      top_next       = top + PTR_W'(1);
      clr_cnt_next   = clr_cnt - CNT_W'(1);
      sts.clear_last = (clr_cnt == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top         <= '0;
      fp          <= '0;
      stack_limit <= LIMIT_RESET;
    end else begin
      if (cfg_we) begin
        stack_limit <= cfg_wdata;
      end
      if (cmd.fire) begin
        top <= top_next;
        fp  <= fp_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      r <= req;
    end
    if (cmd.fire) begin
      clr_cnt <= clr_cnt_next;
    end
    if (cmd.publish) begin
      rsp <= '{status: status, read_word: rword, read_is_ref: rref,
               stack_top: top_next, frame_base: fp_next};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fire && mem_we) begin
      mem[AW'(wr_ptr)] <= wdata;
    end
    if (cmd.fire && mem_re) begin
      rdata <= mem[AW'(rd_ptr)];
    end
  end

  `CSFU_ASSERT_IMPLY(a_wr_in_range, clk, rst, cmd.fire && mem_we, int'(wr_ptr) < STACK_DEPTH, "slot write beyond stack depth")
  `CSFU_ASSERT_IMPLY(a_rd_in_range, clk, rst, cmd.fire && mem_re, int'(rd_ptr) < STACK_DEPTH, "slot read beyond stack depth")
  `CSFU_ASSERT_IMPLY(a_top_bound, clk, rst, 1'b1, int'(top) <= STACK_DEPTH, "stack top beyond stack depth")

endmodule

`default_nettype wire

FILE: rtl/csfu_ctrl.sv
// Controller state machine: request handshake, phase sequencing, result valid.
// Depends on csfu_pkg and call_stack_frame_unit_core_assert.svh.
`default_nettype none
`include "call_stack_frame_unit_core_assert.svh"

module csfu_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  input  csfu_pkg::sts_t   sts,
  output csfu_pkg::cmd_t   cmd
);
  import csfu_pkg::*;

  state_e state, state_next;
  logic   out_valid;
  logic   out_free;

  assign out_free  = !out_valid || rsp_ready;
  assign rsp_valid = out_valid;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_ISSUE;
      end
      S_ISSUE: begin
        if (out_free) begin
          if (sts.go_read)       state_next = S_READ;
          else if (sts.go_clear) state_next = S_CLEAR;
          else                   state_next = S_IDLE;
        end
      end
      S_READ: begin
        if (out_free) state_next = S_IDLE;
      end
      S_CLEAR: begin
        if (sts.clear_last && out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready   = 1'b1;
        cmd.capture = req_valid;
      end
      S_ISSUE: begin
        cmd.ph_issue = 1'b1;
        cmd.fire     = out_free;
        cmd.publish  = out_free && !sts.go_read && !sts.go_clear;
      end
      S_READ: begin
        cmd.ph_read = 1'b1;
        cmd.fire    = out_free;
        cmd.publish = out_free;
      end
      S_CLEAR: begin
        cmd.ph_clear = 1'b1;
        cmd.fire     = !sts.clear_last || out_free;
        cmd.publish  = sts.clear_last && out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.publish)    out_valid <= 1'b1;
      else if (rsp_ready) out_valid <= 1'b0;
    end
  end

  `CSFU_ASSERT_IMPLY(a_no_overwrite, clk, rst, cmd.publish, !out_valid || rsp_ready, "result overwritten before taken")
  `CSFU_ASSERT_NEXT(a_accept_issue, clk, rst, req_valid && req_ready, state == S_ISSUE, "accepted item not issued")
  `CSFU_ASSERT_NEXT(a_clear_stays, clk, rst, state == S_CLEAR && !sts.clear_last, state == S_CLEAR, "local clear ended early")

endmodule

`default_nettype wire

FILE: rtl/call_stack_frame_unit_core.sv
// Path: push, unknown requests and requests refused at issue go capture, issue, result;
// pop, release frame and local access add a read phase (one registered slot read), a
// release refused for its saved slot included; add frame adds clearing of its locals.
// One item at a time; the next is taken once the last result appears; a held result stalls.
// Reset (rst, synchronous): top and frame pointers to 0, limit to 4096, no result pending;
// the slot memory is not cleared and holds garbage until written.
`default_nettype none

// Top level: operand and call stack with frame pointer, split into a
// controller and a datapath. Depends on csfu_pkg, csfu_ctrl, csfu_datapath.
module call_stack_frame_unit_core #(
  parameter int STACK_DEPTH = csfu_pkg::DEF_STACK_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  // request item
  input  logic                       req_valid,
  output logic                       req_ready,
  input  csfu_pkg::csfu_in_t         req,
  // result item, held in an output register until taken
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  output csfu_pkg::csfu_out_t        rsp,
  // stack limit register write
  input  logic                       cfg_we,
  input  logic [csfu_pkg::PTR_W-1:0] cfg_wdata
);
  import csfu_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequence each item: capture, issue (checks, write or read), read
  // completion or local clearing, then hand the result to the output register.
  csfu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Pointers, limit, slot memory (one write and one registered read per cycle).
  csfu_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire
